FILE: src/srjm_pkg.sv
// ----------------------------------------------------------------------------
// srjm_pkg: shared types and constants of the stream rate and jitter monitor
// Transaction payloads, the per-stream state word and the bucket word.
// ----------------------------------------------------------------------------
`default_nettype none

package srjm_pkg;

	localparam int TIME_W = 48;
	localparam int DVD_W  = 48;
	localparam int DVS_W  = 22;
	localparam int CUR_W  = 6;
	localparam logic [9:0] RATE_SCALE = 10'd1000;

	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	typedef struct packed {
		logic        func;
		logic [7:0]  stream_id;
		logic [47:0] arrival_time;
		logic [23:0] packet_bytes;
	} item_t;

	typedef struct packed {
		logic               error;
		logic [31:0]        packet_count;
		logic [47:0]        total_bytes;
		logic [47:0]        first_arrival;
		logic [31:0]        window_bytes;
		logic [31:0]        window_packets;
		logic [31:0]        byte_rate;
		logic signed [47:0] gap_sum;
		logic signed [31:0] gap_min;
		logic signed [31:0] gap_max;
	} result_t;

	typedef struct packed {
		logic [31:0]      packets;
		logic [47:0]      first_time;
		logic [47:0]      last_time;
		logic [CUR_W-1:0] cur;
		logic [47:0]      bytes_total;
		logic [47:0]      gap_total;
		logic [31:0]      gap_low;
		logic [31:0]      gap_high;
	} sword_t;

	typedef struct packed {
		logic [31:0] bytes;
		logic [31:0] pkts;
	} bkt_t;

endpackage

`default_nettype wire

FILE: src/srjm_div.sv
// ----------------------------------------------------------------------------
// srjm_div: bit-serial restoring divider
// One quotient bit per cycle; also tracks the quotient modulo BUCKETS.
// ----------------------------------------------------------------------------
`default_nettype none

module srjm_div #(
	parameter int BUCKETS = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           go,
	input  wire logic [srjm_pkg::DVD_W-1:0]     dividend,
	input  wire logic [srjm_pkg::DVS_W-1:0]     divisor,
	output logic                                done,
	output logic [srjm_pkg::DVD_W-1:0]          quot,
	output logic [$clog2(BUCKETS)-1:0]          qmod
);
	import srjm_pkg::*;

	localparam int BW = $clog2(BUCKETS);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [BW-1:0]    qmod_q;
	logic [5:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   sh;
	logic [DVS_W:0]   diff;
	logic             qbit;
	logic [BW:0]      m2;
	logic [BW-1:0]    m_next;

	always_comb begin
		sh   = {rem_q, dvd_q[DVD_W-1]};
		diff = sh - {1'b0, dvs_q};
		qbit = (sh >= {1'b0, dvs_q});
		m2   = {qmod_q, qbit};
		if (m2 >= (BW+1)'(BUCKETS)) begin
			m_next = BW'(m2 - (BW+1)'(BUCKETS));
		end else begin
			m_next = BW'(m2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(DVD_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			qmod_q <= '0;
		end else if (run_q) begin
			rem_q  <= qbit ? DVS_W'(diff) : DVS_W'(sh);
			dvd_q  <= {dvd_q[DVD_W-2:0], qbit};
			qmod_q <= m_next;
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign qmod = qmod_q;

endmodule

`default_nettype wire

FILE: src/stream_rate_jitter_monitor.sv
// ----------------------------------------------------------------------------
// stream_rate_jitter_monitor: per-stream packet statistics and byte rate
// Keeps counters, gap statistics and a ring of time buckets for each stream
// in two synchronous memories and answers every transaction with the stats.
// ----------------------------------------------------------------------------
//
// Channel   Signals                  Direction  Handshake
// command   start, in_item, busy     in         taken when start && !busy
// result    done, result             out        one cycle pulse on done
// config    cfg_we, cfg_data         in         written when cfg_we
//
// After reset a clearing pass walks the bucket memory, one entry a cycle,
// with busy held high. A record transaction reads the stream word, runs
// the serial divider for the bucket index, clears each bucket skipped when
// the index moves and the newly entered one, updates that bucket, sums the
// window one entry a cycle and runs a second divider pass for the byte rate
// before raising done. A read skips the index pass and the bucket update.
// Each pass of the serial divider has 48 steps.
// An out-of-range stream gets an error result in the cycle after start.
// The receiver cannot stall: done marks each result for one cycle only.
//
`default_nettype none

module stream_rate_jitter_monitor #(
	parameter int STREAMS = 8,
	parameter int BUCKETS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire srjm_pkg::item_t  in_item,
	output logic                  done,
	output srjm_pkg::result_t     result,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_data
);
	import srjm_pkg::*;

	localparam int SW  = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int BW  = $clog2(BUCKETS);
	localparam int AW  = $clog2(STREAMS * BUCKETS);
	localparam int ACW = 32 + BW;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SRD, S_TDIV, S_CLR, S_URD, S_UWR,
		S_SUM, S_MUL, S_RST, S_RDIV
	} state_t;

	state_t state_q;

	// Storage: per-stream state word and the bucket ring of every stream.
	sword_t smem [STREAMS];
	bkt_t   bmem [STREAMS * BUCKETS];

	logic [15:0]      cfg_q;
	logic [15:0]      iv_eff;
	item_t            item_q;
	sword_t           srd_q;
	sword_t           sword_q;
	sword_t           snew;
	bkt_t             brd_q;
	logic [AW-1:0]    clr_q;
	logic [BW-1:0]    j_q;
	logic [BW-1:0]    idx_q;
	logic [BW-1:0]    cnt_q;
	logic             rv_q;
	logic [ACW-1:0]   wb_q;
	logic [ACW-1:0]   wp_q;
	logic [DVD_W-1:0] prod_q;
	logic [DVS_W-1:0] den_q;
	logic             done_q;
	result_t          res_q;

	logic             s_re;
	logic             s_we;
	logic [SW-1:0]    s_ra;
	logic [SW-1:0]    s_wa;
	sword_t           s_wd;
	logic             b_re;
	logic             b_we;
	logic [AW-1:0]    b_ra;
	logic [AW-1:0]    b_wa;
	bkt_t             b_wd;
	logic [SW-1:0]    sid;
	logic [31:0]      gap;
	logic             div_go;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [DVD_W-1:0] div_q;
	logic [BW-1:0]    div_m;
	logic [BW-1:0]    cur;

	function automatic logic [BW-1:0] wrap_inc(input logic [BW-1:0] v);
		logic [BW-1:0] r;
		if (v == BW'(BUCKETS - 1)) begin
			r = '0;
		end else begin
			r = v + BW'(1);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] baddr(input logic [SW-1:0] s, input logic [BW-1:0] b);
		logic [AW:0] a;
		a = (AW+1)'(s) * (AW+1)'(BUCKETS) + (AW+1)'(b);
		return AW'(a);
	endfunction

	assign iv_eff = (cfg_q == 16'd0) ? 16'd1 : cfg_q;
	assign sid    = SW'(item_q.stream_id);
	assign cur    = BW'(sword_q.cur);

	// Record update of the stream word, everything but the bucket index.
	always_comb begin
		snew = srd_q;
		gap  = item_q.arrival_time[31:0] - srd_q.last_time[31:0];
		if (item_q.func == FUNC_RECORD) begin
			if (srd_q.packets == 32'd0) begin
				snew.first_time = item_q.arrival_time;
			end else begin
				snew.gap_total = srd_q.gap_total + {{16{gap[31]}}, gap};
				if (srd_q.packets == 32'd1) begin
					snew.gap_low  = gap;
					snew.gap_high = gap;
				end else begin
					if ($signed(gap) > $signed(srd_q.gap_high)) begin
						snew.gap_high = gap;
					end
					if ($signed(gap) < $signed(srd_q.gap_low)) begin
						snew.gap_low = gap;
					end
				end
			end
			snew.packets     = srd_q.packets + 32'd1;
			snew.last_time   = item_q.arrival_time;
			snew.bytes_total = srd_q.bytes_total + 48'(item_q.packet_bytes);
		end
	end

	// Memory port selection by state.
	always_comb begin
		s_re = 1'b0;
		s_ra = SW'(in_item.stream_id);
		s_we = 1'b0;
		s_wa = sid;
		s_wd = sword_q;
		b_re = 1'b0;
		b_ra = baddr(sid, j_q);
		b_we = 1'b0;
		b_wa = baddr(sid, j_q);
		b_wd = '0;
		div_go  = 1'b0;
		div_dvd = prod_q;
		div_dvs = den_q;
		unique case (state_q)
			S_INIT: begin
				b_we = 1'b1;
				b_wa = clr_q;
				s_we = (clr_q < AW'(STREAMS));
				s_wa = clr_q[SW-1:0];
				s_wd = '0;
			end
			S_IDLE: begin
				s_re = start && (in_item.stream_id < 8'(STREAMS));
			end
			S_SRD: begin
				div_go  = (item_q.func == FUNC_RECORD);
				div_dvd = item_q.arrival_time;
				div_dvs = DVS_W'(iv_eff);
			end
			S_CLR: begin
				b_we = 1'b1;
			end
			S_URD: begin
				b_re = 1'b1;
				b_ra = baddr(sid, idx_q);
			end
			S_UWR: begin
				b_we       = 1'b1;
				b_wa       = baddr(sid, idx_q);
				b_wd.bytes = brd_q.bytes + 32'(item_q.packet_bytes);
				b_wd.pkts  = brd_q.pkts + 32'd1;
				s_we       = 1'b1;
			end
			S_SUM: begin
				b_re = (cnt_q != BW'(BUCKETS - 1));
			end
			S_RST: begin
				div_go = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			smem[s_wa] <= s_wd;
		end
		if (s_re) begin
			srd_q <= smem[s_ra];
		end
		if (b_we) begin
			bmem[b_wa] <= b_wd;
		end
		if (b_re) begin
			brd_q <= bmem[b_ra];
		end
	end

	srjm_div #(.BUCKETS(BUCKETS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_q),
		.qmod     (div_m)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cfg_q   <= 16'd1;
			clr_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
			item_q  <= '0;
			sword_q <= '0;
			j_q     <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			rv_q    <= 1'b0;
			wb_q    <= '0;
			wp_q    <= '0;
			prod_q  <= '0;
			den_q   <= '0;
		end else begin
			done_q <= 1'b0;
			rv_q   <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (rv_q) begin
				wb_q <= wb_q + ACW'(brd_q.bytes);
				wp_q <= wp_q + ACW'(brd_q.pkts);
			end
			unique case (state_q)
				S_INIT: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(STREAMS * BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						item_q <= in_item;
						if (in_item.stream_id >= 8'(STREAMS)) begin
							res_q  <= '{error: 1'b1, default: '0};
							done_q <= 1'b1;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					sword_q <= snew;
					if (item_q.func == FUNC_RECORD) begin
						state_q <= S_TDIV;
					end else begin
						j_q     <= wrap_inc(BW'(snew.cur));
						cnt_q   <= '0;
						wb_q    <= '0;
						wp_q    <= '0;
						state_q <= S_SUM;
					end
				end
				S_TDIV: begin
					if (div_done) begin
						idx_q       <= div_m;
						sword_q.cur <= CUR_W'(div_m);
						j_q         <= wrap_inc(cur);
						if (cur != div_m) begin
							state_q <= S_CLR;
						end else begin
							state_q <= S_URD;
						end
					end
				end
				S_CLR: begin
					// Skipped buckets and the newly entered one start from zero.
					if (j_q == idx_q) begin
						state_q <= S_URD;
					end else begin
						j_q <= wrap_inc(j_q);
					end
				end
				S_URD: begin
					state_q <= S_UWR;
				end
				S_UWR: begin
					j_q     <= wrap_inc(idx_q);
					cnt_q   <= '0;
					wb_q    <= '0;
					wp_q    <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (cnt_q != BW'(BUCKETS - 1)) begin
						rv_q  <= 1'b1;
						cnt_q <= cnt_q + BW'(1);
						j_q   <= wrap_inc(j_q);
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// Full-width product: the window sum times 1000 needs up to 45 bits.
					prod_q  <= DVD_W'(wb_q) * DVD_W'(RATE_SCALE);
					den_q   <= DVS_W'(BUCKETS - 1) * DVS_W'(iv_eff);
					state_q <= S_RST;
				end
				S_RST: begin
					state_q <= S_RDIV;
				end
				S_RDIV: begin
					if (div_done) begin
						res_q <= '{
							error:          1'b0,
							packet_count:   sword_q.packets,
							total_bytes:    sword_q.bytes_total,
							first_arrival:  sword_q.first_time,
							window_bytes:   (|wb_q[ACW-1:32]) ? '1 : wb_q[31:0],
							window_packets: (|wp_q[ACW-1:32]) ? '1 : wp_q[31:0],
							byte_rate:      (|div_q[DVD_W-1:32]) ? '1 : div_q[31:0],
							gap_sum:        sword_q.gap_total,
							gap_min:        sword_q.gap_low,
							gap_max:        sword_q.gap_high
						};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

FILE: src/srjm_chk.sv
// ----------------------------------------------------------------------------
// srjm_chk: port-level checks of the stream rate and jitter monitor
// Bound to the top level; watches transactions and results over time.
// ----------------------------------------------------------------------------
`default_nettype none

module srjm_chk #(
	parameter int STREAMS = 8
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire srjm_pkg::item_t   in_item,
	input wire logic              done,
	input wire srjm_pkg::result_t result
);
	import srjm_pkg::*;

	a_err_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (in_item.stream_id >= 8'(STREAMS)) |=> done && result.error)
		else $error("out-of-range stream did not answer with an error");

	a_ok_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (in_item.stream_id < 8'(STREAMS)) |=> busy && !done)
		else $error("valid transaction did not hold busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.error |-> result.packet_count == 32'd0 &&
		result.window_bytes == 32'd0 && result.byte_rate == 32'd0)
		else $error("error result carries statistics");

	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.error |-> result.gap_min <= result.gap_max)
		else $error("gap minimum above gap maximum");

endmodule

bind stream_rate_jitter_monitor srjm_chk #(.STREAMS(STREAMS)) u_srjm_chk (.*);

`default_nettype wire
